### hw/rtl/tun_pkg.sv
package tun_pkg;

    // Fixed field geometry of the stream
    localparam int FIELD_WIDTH      = 32;
    localparam int IN_FIELDS        = 9;
    localparam int OUT_WIDTH        = 16;
    localparam int OUT_FIELDS       = 3;

    // Defaults for the top-level parameters
    localparam int COORD_WIDTH_DEF      = 32;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    // Per-transaction side information carried down the pipe
    typedef struct packed {
        logic       degenerate;
        logic [2:0] neg;
    } tun_ctrl_t;

endpackage

### hw/rtl/tun_front.sv
module tun_front
    import tun_pkg::*;
#(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF,
    localparam int EW  = COORD_WIDTH + 1,
    localparam int MW  = 2 * EW,
    localparam int NW  = MW + 1,
    localparam int HW  = EW,
    localparam int SW  = 2 * MW,
    localparam int SSW = SW + 2,
    localparam int DW  = SSW + 2 * NORMAL_FRAC_BITS + 3
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [IN_FIELDS*FIELD_WIDTH-1:0]   in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [SSW-1:0]                     out_sum,
    output logic [2:0][DW-1:0]                 out_rem,
    output tun_ctrl_t                          out_ctrl
);

    localparam int NST = 6;

    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;

    logic signed [EW-1:0]   crd    [IN_FIELDS];
    logic signed [EW-1:0]   e1_reg [3];
    logic signed [EW-1:0]   e2_reg [3];
    logic signed [2*EW-1:0] pp_reg [3];
    logic signed [2*EW-1:0] pn_reg [3];
    logic [MW-1:0]          mag_reg [3];
    logic [2:0]             neg3_reg, neg4_reg, neg5_reg, neg6_reg;
    logic [2*HW-1:0]        ll_reg [3];
    logic [2*HW-1:0]        hl_reg [3];
    logic [2*HW-1:0]        hh_reg [3];
    logic [SW-1:0]          sq_reg [3];
    logic [SSW-1:0]         sum_reg;
    logic [2:0][DW-1:0]     rem_reg;
    logic                   degen_reg;
    logic signed [NW-1:0]   n_next [3];
    logic [SSW-1:0]         sum_next;

    // Ready chain: a stage moves when it is empty or the next one moves
    always_comb begin
        rdy[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end
    assign in_ready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) v_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // Low COORD_WIDTH bits of each field, sign-extended by one bit
    always_comb begin
        for (int i = 0; i < IN_FIELDS; i++) begin
            crd[i] = signed'({in_data[i*FIELD_WIDTH+COORD_WIDTH-1],
                              in_data[i*FIELD_WIDTH +: COORD_WIDTH]});
        end
    end

    // Stage 1: edge vectors
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            for (int j = 0; j < 3; j++) begin
                e1_reg[j] <= crd[3+j] - crd[j];
                e2_reg[j] <= crd[6+j] - crd[j];
            end
        end
    end

    // Stage 2: cross-product partial terms
    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            for (int i = 0; i < 3; i++) begin
                pp_reg[i] <= e1_reg[(i+1)%3] * e2_reg[(i+2)%3];
                pn_reg[i] <= e1_reg[(i+2)%3] * e2_reg[(i+1)%3];
            end
        end
    end

    // Stage 3: cross product, split into sign and magnitude
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_next[i] = {pp_reg[i][2*EW-1], pp_reg[i]} - {pn_reg[i][2*EW-1], pn_reg[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            for (int i = 0; i < 3; i++) begin
                neg3_reg[i] <= n_next[i][NW-1];
                mag_reg[i]  <= n_next[i][NW-1] ? MW'(-n_next[i]) : MW'(n_next[i]);
            end
        end
    end

    // Stage 4: partial products of the squares
    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            neg4_reg <= neg3_reg;
            for (int i = 0; i < 3; i++) begin
                ll_reg[i] <= mag_reg[i][HW-1:0] * mag_reg[i][HW-1:0];
                hl_reg[i] <= mag_reg[i][MW-1:HW] * mag_reg[i][HW-1:0];
                hh_reg[i] <= mag_reg[i][MW-1:HW] * mag_reg[i][MW-1:HW];
            end
        end
    end

    // Stage 5: squared components
    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            neg5_reg <= neg4_reg;
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= (SW'(hh_reg[i]) << MW) + (SW'(hl_reg[i]) << (HW + 1))
                             + SW'(ll_reg[i]);
            end
        end
    end

    // Stage 6: squared length and scaled remainders
    assign sum_next = SSW'(sq_reg[0]) + SSW'(sq_reg[1]) + SSW'(sq_reg[2]);

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            neg6_reg  <= neg5_reg;
            sum_reg   <= sum_next;
            degen_reg <= (sum_next == '0);
            for (int i = 0; i < 3; i++) begin
                rem_reg[i] <= DW'(sq_reg[i]) << (2 * NORMAL_FRAC_BITS);
            end
        end
    end

    assign out_valid           = v_reg[NST-1];
    assign out_sum             = sum_reg;
    assign out_rem             = rem_reg;
    assign out_ctrl.degenerate = degen_reg;
    assign out_ctrl.neg        = neg6_reg;

endmodule

### hw/rtl/tun_cell.sv
module tun_cell
    import tun_pkg::*;
#(
    parameter int SUM_W = 136,
    parameter int REM_W = 167,
    parameter int ACC_W = 151,
    parameter int Q_W   = 15,
    parameter int BIT   = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [SUM_W-1:0]      in_sum,
    input  logic [2:0][REM_W-1:0] in_rem,
    input  logic [2:0][ACC_W-1:0] in_acc,
    input  logic [2:0][Q_W-1:0]   in_q,
    input  tun_ctrl_t             in_ctrl,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SUM_W-1:0]      out_sum,
    output logic [2:0][REM_W-1:0] out_rem,
    output logic [2:0][ACC_W-1:0] out_acc,
    output logic [2:0][Q_W-1:0]   out_q,
    output tun_ctrl_t             out_ctrl
);

    logic                  v_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [2:0][REM_W-1:0] rem_reg, rem_next;
    logic [2:0][ACC_W-1:0] acc_reg, acc_next;
    logic [2:0][Q_W-1:0]   q_reg, q_next;
    tun_ctrl_t             ctrl_reg;
    logic [2:0][REM_W-1:0] delta;

    assign in_ready = !v_reg || out_ready;

    // One result bit per lane: try q + 2^BIT against the remainder
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            delta[i] = (REM_W'(in_acc[i]) << (BIT + 1)) + (REM_W'(in_sum) << (2 * BIT));
            if (delta[i] <= in_rem[i]) begin
                rem_next[i] = in_rem[i] - delta[i];
                acc_next[i] = in_acc[i] + (ACC_W'(in_sum) << BIT);
                q_next[i]   = in_q[i] | (Q_W'(1) << BIT);
            end else begin
                rem_next[i] = in_rem[i];
                acc_next[i] = in_acc[i];
                q_next[i]   = in_q[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            sum_reg  <= in_sum;
            rem_reg  <= rem_next;
            acc_reg  <= acc_next;
            q_reg    <= q_next;
            ctrl_reg <= in_ctrl;
        end
    end

    assign out_valid = v_reg;
    assign out_sum   = sum_reg;
    assign out_rem   = rem_reg;
    assign out_acc   = acc_reg;
    assign out_q     = q_reg;
    assign out_ctrl  = ctrl_reg;

endmodule

### hw/rtl/triangle_unit_normal_unit.sv
// Unit normal of a triangle: takes vertices a, b, c (signed Q16.16) and returns
// (b-a) x (c-a) divided by its length in signed Q2.14, truncated toward zero,
// with a degenerate flag (and a zero vector) when the cross product vanishes.
// One transaction is accepted per clock while m_tready does not hold the pipe:
// six front stages compute edges, cross product and squared length, then a
// chain of NORMAL_FRAC_BITS+1 cells each settle one result bit by an exact
// restoring compare, then the output register. cfg_wdata[0]
// written with cfg_we negates the normal; write it only while the unit is idle.
module triangle_unit_normal_unit
    import tun_pkg::*;
#(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic                             cfg_wdata,     // flip_normal
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, 32 bits each
    input  logic [IN_FIELDS*FIELD_WIDTH-1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // normal_x, normal_y, normal_z, 16 bits each
    output logic [OUT_FIELDS*OUT_WIDTH-1:0]  m_tdata,
    // degenerate
    output logic                             m_tuser
);

    localparam int EW    = COORD_WIDTH + 1;
    localparam int MW    = 2 * EW;
    localparam int SW    = 2 * MW;
    localparam int SSW   = SW + 2;
    localparam int DW    = SSW + 2 * NORMAL_FRAC_BITS + 3;
    localparam int PW    = SSW + NORMAL_FRAC_BITS + 1;
    localparam int QW    = NORMAL_FRAC_BITS + 1;
    localparam int NCELL = NORMAL_FRAC_BITS + 1;
    localparam int RW    = QW + OUT_WIDTH;

    logic                   flip_reg;
    logic                   ch_valid [NCELL+1];
    logic                   ch_ready [NCELL+1];
    logic [SSW-1:0]         ch_sum   [NCELL+1];
    logic [2:0][DW-1:0]     ch_rem   [NCELL+1];
    logic [2:0][PW-1:0]     ch_acc   [NCELL+1];
    logic [2:0][QW-1:0]     ch_q     [NCELL+1];
    tun_ctrl_t              ch_ctrl  [NCELL+1];
    logic                   out_v_reg;
    logic                   out_ready;
    logic [OUT_FIELDS*OUT_WIDTH-1:0] data_reg, data_next;
    logic                   degen_reg;
    logic [RW-1:0]          mag    [OUT_FIELDS];
    logic [RW-1:0]          signed_val [OUT_FIELDS];

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flip_reg <= 1'b0;
        end else if (cfg_we) begin
            flip_reg <= cfg_wdata;
        end
    end

    tun_front #(
        .COORD_WIDTH      (COORD_WIDTH),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (ch_valid[0]),
        .out_ready (ch_ready[0]),
        .out_sum   (ch_sum[0]),
        .out_rem   (ch_rem[0]),
        .out_ctrl  (ch_ctrl[0])
    );

    assign ch_acc[0] = '0;
    assign ch_q[0]   = '0;

    // Root chain, most significant bit first
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        tun_cell #(
            .SUM_W (SSW),
            .REM_W (DW),
            .ACC_W (PW),
            .Q_W   (QW),
            .BIT   (NORMAL_FRAC_BITS - k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (ch_valid[k]),
            .in_ready  (ch_ready[k]),
            .in_sum    (ch_sum[k]),
            .in_rem    (ch_rem[k]),
            .in_acc    (ch_acc[k]),
            .in_q      (ch_q[k]),
            .in_ctrl   (ch_ctrl[k]),
            .out_valid (ch_valid[k+1]),
            .out_ready (ch_ready[k+1]),
            .out_sum   (ch_sum[k+1]),
            .out_rem   (ch_rem[k+1]),
            .out_acc   (ch_acc[k+1]),
            .out_q     (ch_q[k+1]),
            .out_ctrl  (ch_ctrl[k+1])
        );
    end

    // Sign, flip and field masking
    always_comb begin
        for (int i = 0; i < OUT_FIELDS; i++) begin
            mag[i] = RW'(ch_q[NCELL][i]);
            signed_val[i] = (ch_ctrl[NCELL].neg[i] ^ flip_reg) ? -mag[i] : mag[i];
            data_next[i*OUT_WIDTH +: OUT_WIDTH] =
                ch_ctrl[NCELL].degenerate ? '0 : signed_val[i][OUT_WIDTH-1:0];
        end
    end

    // Output register
    assign out_ready       = !out_v_reg || m_tready;
    assign ch_ready[NCELL] = out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (out_ready) begin
            out_v_reg <= ch_valid[NCELL];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            data_reg  <= data_next;
            degen_reg <= ch_ctrl[NCELL].degenerate;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = degen_reg;

    // A degenerate triangle always leaves as the zero vector
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("degenerate transaction with non-zero normal");

    // With the output register empty the whole pipe can move
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register empty");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
